// ===== rtl/frxu_pkg.sv =====
package frxu_pkg;

  // machine sizes
  localparam int MAX_LINES   = 128;
  localparam int LINE_W      = 7;
  localparam int LEN_W       = 8;
  localparam int DATA_W      = 32;
  localparam int NUM_REGS    = 4;
  localparam int REG_IDX_W   = 2;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  // operation codes
  localparam logic [3:0] OP_NOOP  = 4'd0;
  localparam logic [3:0] OP_JMP   = 4'd1;
  localparam logic [3:0] OP_JE    = 4'd2;
  localparam logic [3:0] OP_JNE   = 4'd3;
  localparam logic [3:0] OP_JG    = 4'd4;
  localparam logic [3:0] OP_JGE   = 4'd5;
  localparam logic [3:0] OP_JL    = 4'd6;
  localparam logic [3:0] OP_JLE   = 4'd7;
  localparam logic [3:0] OP_ADD   = 4'd8;
  localparam logic [3:0] OP_SUB   = 4'd9;
  localparam logic [3:0] OP_MUL   = 4'd10;
  localparam logic [3:0] OP_DIV   = 4'd11;
  localparam logic [3:0] OP_MOV   = 4'd12;
  localparam logic [3:0] OP_READ  = 4'd13;
  localparam logic [3:0] OP_PRINT = 4'd14;

  // input transfer payload
  typedef struct packed {
    logic [3:0]                  operation;
    logic                        first_is_reg;
    logic [REG_IDX_W-1:0]        first_reg;
    logic signed [DATA_W-1:0]    first_imm;
    logic                        second_is_reg;
    logic [REG_IDX_W-1:0]        second_reg;
    logic signed [DATA_W-1:0]    second_imm;
    logic [LINE_W-1:0]           jump_target;
    logic signed [DATA_W-1:0]    read_value;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [LINE_W-1:0]           next_line;
    logic                        halted;
    logic                        print_valid;
    logic signed [DATA_W-1:0]    print_value;
    logic                        divide_error;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic div_start;
    logic div_wr;
    logic push;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/four_register_instruction_execute_unit.sv =====
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready  | frxu_pkg::in_item_t
// out_     | output    | out_valid / out_ready| frxu_pkg::out_item_t
// cfg_     | input     | cfg_we               | program length, 8 bits
//
// one instruction at a time: transfer in, execute, push to the output register,
// stepping through the states S_IDLE, S_EXEC and S_DONE, out_valid registered at the push
// div with a nonzero divisor waits in S_DIV on the one-bit-per-cycle divider;
// a finished result waits in the output register while the next transfer is taken,
// the next push holding until out_ready frees that register
// rst_n is synchronous: registers zero, line zero, not halted, program length zero
module four_register_instruction_execute_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  frxu_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output frxu_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [frxu_pkg::LEN_W-1:0]   cfg_wdata
);

  frxu_pkg::cmd_t  cmd;
  frxu_pkg::stat_t st;

  // sequencer
  frxu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // register file, execution and result register
  frxu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/frxu_ram.sv =====
module frxu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [WIDTH-1:0]           rdata_a,
  output logic [WIDTH-1:0]           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/frxu_div.sv =====
module frxu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [frxu_pkg::DATA_W-1:0]  dividend,
  input  logic [frxu_pkg::DATA_W-1:0]  divisor,
  output logic                         done,
  output logic [frxu_pkg::DATA_W-1:0]  quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic                              neg_r;
  logic [frxu_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [frxu_pkg::DATA_W-1:0]       quo_r;
  logic [frxu_pkg::DATA_W-1:0]       den_r;
  logic [frxu_pkg::DATA_W-1:0]       rem_r;
  logic [frxu_pkg::DATA_W:0]         shifted;
  logic                              fits;
  logic [frxu_pkg::DATA_W:0]         diff;
  logic [frxu_pkg::DATA_W-1:0]       mag_a;
  logic [frxu_pkg::DATA_W-1:0]       mag_b;

  // operand magnitudes, most negative value maps to itself unsigned
  assign mag_a = dividend[frxu_pkg::DATA_W-1] ? -dividend : dividend;
  assign mag_b = divisor[frxu_pkg::DATA_W-1]  ? -divisor  : divisor;

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[frxu_pkg::DATA_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == frxu_pkg::DIV_CNT_W'(frxu_pkg::DATA_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag_a;
      den_r <= mag_b;
      rem_r <= '0;
      cnt_r <= '0;
      neg_r <= dividend[frxu_pkg::DATA_W-1] ^ divisor[frxu_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? diff[frxu_pkg::DATA_W-1:0] : shifted[frxu_pkg::DATA_W-1:0];
      quo_r <= {quo_r[frxu_pkg::DATA_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // sign fix, truncation toward zero
  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

// ===== rtl/frxu_dp.sv =====
module frxu_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  frxu_pkg::in_item_t                   in_data,
  input  logic                                 cfg_we,
  input  logic [frxu_pkg::LEN_W-1:0]           cfg_wdata,
  input  frxu_pkg::cmd_t                       cmd,
  output frxu_pkg::stat_t                      st,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output frxu_pkg::out_item_t                  out_data
);

  frxu_pkg::in_item_t                  item_r;
  frxu_pkg::out_item_t                 res_r;
  frxu_pkg::out_item_t                 out_r;
  frxu_pkg::out_item_t                 res_nxt;
  logic                                out_valid_r;
  logic [frxu_pkg::LEN_W-1:0]          prog_len_r;
  logic [frxu_pkg::LINE_W-1:0]         lc_r;
  logic                                stopped_r;
  logic [frxu_pkg::NUM_REGS-1:0]       vld_r;
  logic                                rdv_a_r;
  logic                                rdv_b_r;

  logic [frxu_pkg::DATA_W-1:0]         ram_a;
  logic [frxu_pkg::DATA_W-1:0]         ram_b;
  logic [frxu_pkg::DATA_W-1:0]         reg_f;
  logic [frxu_pkg::DATA_W-1:0]         dv;
  logic [frxu_pkg::DATA_W-1:0]         fv;
  logic [frxu_pkg::DATA_W-1:0]         sv;
  logic [frxu_pkg::LEN_W-1:0]          len;
  logic [frxu_pkg::LEN_W-1:0]          next;
  logic                                halt_in;
  logic                                halt_out;
  logic                                taken;
  logic                                ex_we;
  logic [frxu_pkg::REG_IDX_W-1:0]      ex_waddr;
  logic [frxu_pkg::DATA_W-1:0]         ex_wdata;
  logic                                ram_we;
  logic [frxu_pkg::REG_IDX_W-1:0]      ram_waddr;
  logic [frxu_pkg::DATA_W-1:0]         ram_wdata;
  logic                                div_done;
  logic [frxu_pkg::DATA_W-1:0]         div_q;

  // configuration and item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_we) begin
      prog_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
  end

  // register file, read at acceptance
  frxu_ram #(
    .WIDTH (frxu_pkg::DATA_W),
    .DEPTH (frxu_pkg::NUM_REGS)
  ) u_rf (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.accept),
    .raddr_a (in_data.first_reg),
    .raddr_b (in_data.second_reg),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdv_a_r <= vld_r[in_data.first_reg];
      rdv_b_r <= vld_r[in_data.second_reg];
    end
  end

  // operand selection
  assign reg_f = rdv_a_r ? ram_a : '0;
  assign dv    = rdv_b_r ? ram_b : '0;
  assign fv    = item_r.first_is_reg  ? reg_f : item_r.first_imm;
  assign sv    = item_r.second_is_reg ? dv    : item_r.second_imm;

  // effective program length and halt checks
  assign len      = (prog_len_r > frxu_pkg::LEN_W'(frxu_pkg::MAX_LINES)) ?
                    frxu_pkg::LEN_W'(frxu_pkg::MAX_LINES) : prog_len_r;
  assign halt_in  = stopped_r || ({1'b0, lc_r} >= len);
  assign next     = taken ? {1'b0, item_r.jump_target} : ({1'b0, lc_r} + 1'b1);
  assign halt_out = next >= len;

  // instruction decode
  always_comb begin
    taken    = 1'b0;
    ex_we    = 1'b0;
    ex_waddr = item_r.second_reg;
    ex_wdata = fv;
    unique case (item_r.operation)
      frxu_pkg::OP_JMP: taken = 1'b1;
      frxu_pkg::OP_JE:  taken = $signed(fv) == $signed(sv);
      frxu_pkg::OP_JNE: taken = $signed(fv) != $signed(sv);
      frxu_pkg::OP_JG:  taken = $signed(fv) >  $signed(sv);
      frxu_pkg::OP_JGE: taken = $signed(fv) >= $signed(sv);
      frxu_pkg::OP_JL:  taken = $signed(fv) <  $signed(sv);
      frxu_pkg::OP_JLE: taken = $signed(fv) <= $signed(sv);
      frxu_pkg::OP_ADD: begin
        ex_we    = 1'b1;
        ex_wdata = fv + dv;
      end
      frxu_pkg::OP_SUB: begin
        ex_we    = 1'b1;
        ex_wdata = dv - fv;
      end
      frxu_pkg::OP_MUL: begin
        ex_we    = 1'b1;
        ex_wdata = fv * dv;
      end
      frxu_pkg::OP_MOV: begin
        ex_we    = 1'b1;
        ex_wdata = fv;
      end
      frxu_pkg::OP_READ: begin
        ex_we    = 1'b1;
        ex_waddr = item_r.first_reg;
        ex_wdata = item_r.read_value;
      end
      default: begin
        taken = 1'b0;
      end
    endcase
  end

  // register file write: direct result or quotient
  assign ram_we    = (cmd.exec && !halt_in && ex_we) || cmd.div_wr;
  assign ram_waddr = cmd.div_wr ? item_r.second_reg : ex_waddr;
  assign ram_wdata = cmd.div_wr ? div_q : ex_wdata;

  frxu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (fv),
    .divisor  (dv),
    .done     (div_done),
    .quotient (div_q)
  );

  // result of the instruction
  always_comb begin
    res_nxt = '0;
    if (halt_in) begin
      res_nxt.halted = 1'b1;
    end else begin
      res_nxt.halted       = halt_out;
      res_nxt.next_line    = halt_out ? '0 : next[frxu_pkg::LINE_W-1:0];
      res_nxt.print_valid  = item_r.operation == frxu_pkg::OP_PRINT;
      res_nxt.print_value  = (item_r.operation == frxu_pkg::OP_PRINT) ? fv : '0;
      res_nxt.divide_error = (item_r.operation == frxu_pkg::OP_DIV) && (dv == '0);
    end
  end

  // line counter and halt flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r      <= '0;
      stopped_r <= 1'b0;
    end else if (cmd.exec) begin
      if (halt_in || halt_out) begin
        stopped_r <= 1'b1;
      end else begin
        lc_r <= next[frxu_pkg::LINE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_r <= res_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign st.need_div = !halt_in && (item_r.operation == frxu_pkg::OP_DIV) && (dv != '0);
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;

  // checks
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("halt flag cleared without reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.push)
    else $error("waiting result overwritten");

endmodule

// ===== rtl/frxu_ctrl.sv =====
module frxu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  frxu_pkg::stat_t  st,
  output frxu_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of one instruction
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = st.need_div;
        state_nxt     = st.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // checks
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.exec)
    else $error("accepted transfer not executed");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_DIV))
    else $error("quotient ready outside divide wait");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import frxu_pkg::*;

  // operation code the block does not define, executed as a no-op
  localparam logic [3:0] OP_UNUSED = 4'd15;

  // ways the program is brought to its end
  localparam int END_SHRINK   = 0;
  localparam int END_JUMP_OUT = 1;
  localparam int END_RUN_OFF  = 2;

  localparam int LIMIT = 400000;
  localparam int TAIL  = 40;

  // architectural state tracked alongside the block
  typedef struct packed {
    logic [NUM_REGS-1:0][DATA_W-1:0] regs;
    logic [LINE_W-1:0]               line;
    logic                            stopped;
    logic [LEN_W-1:0]                prog_len;
  } machine_t;

  class exec_scoreboard;
    machine_t  mach;
    out_item_t result_q[$];
    int        errors;
    int        checked;
    int        prints;
    int        div_errors;
    int        halts;

    function new();
      mach = '0;
      errors = 0;
      checked = 0;
      prints = 0;
      div_errors = 0;
      halts = 0;
    endfunction

    // lengths above the line store size act as the full store
    function int cap_len(input logic [LEN_W-1:0] v);
      return (int'(v) > MAX_LINES) ? MAX_LINES : int'(v);
    endfunction

    // execute one instruction on a copy of the machine
    function void run_instr(input machine_t s, input in_item_t it,
                            output machine_t n, output out_item_t r);
      int                len;
      int                nxt;
      logic [DATA_W-1:0] fv;
      logic [DATA_W-1:0] sv;
      logic [DATA_W-1:0] dv;
      longint            a;
      longint            b;
      longint            q;
      logic              taken;
      n = s;
      r = '0;
      taken = 1'b0;
      len = cap_len(s.prog_len);
      // halted, or the line is past the end: nothing runs
      if (s.stopped || int'(s.line) >= len) begin
        n.stopped = 1'b1;
        r.halted = 1'b1;
        return;
      end
      fv = it.first_is_reg ? s.regs[it.first_reg] : it.first_imm;
      sv = it.second_is_reg ? s.regs[it.second_reg] : it.second_imm;
      dv = s.regs[it.second_reg];
      a = longint'($signed(fv));
      b = longint'($signed(sv));
      case (it.operation)
        OP_JMP:   taken = 1'b1;
        OP_JE:    taken = (a == b);
        OP_JNE:   taken = (a != b);
        OP_JG:    taken = (a > b);
        OP_JGE:   taken = (a >= b);
        OP_JL:    taken = (a < b);
        OP_JLE:   taken = (a <= b);
        OP_ADD:   n.regs[it.second_reg] = fv + dv;
        OP_SUB:   n.regs[it.second_reg] = dv - fv;
        OP_MUL:   n.regs[it.second_reg] = fv * dv;
        OP_DIV: begin
          // zero divisor flags and keeps the register
          if (dv == '0) begin
            r.divide_error = 1'b1;
          end else begin
            q = a / longint'($signed(dv));
            n.regs[it.second_reg] = q[DATA_W-1:0];
          end
        end
        OP_MOV:   n.regs[it.second_reg] = fv;
        OP_READ:  n.regs[it.first_reg] = it.read_value;
        OP_PRINT: begin
          r.print_valid = 1'b1;
          r.print_value = fv;
        end
        default: ;
      endcase
      // next line, or halt when it falls outside the program
      nxt = taken ? int'(it.jump_target) : int'(s.line) + 1;
      if (nxt >= len) begin
        n.stopped = 1'b1;
        r.halted = 1'b1;
      end else begin
        n.line = LINE_W'(nxt);
        r.next_line = n.line;
      end
    endfunction

    function void set_prog_len(input logic [LEN_W-1:0] v);
      mach.prog_len = v;
    endfunction

    function bit would_halt(input in_item_t it);
      machine_t  n;
      out_item_t r;
      run_instr(mach, it, n, r);
      return r.halted;
    endfunction

    // accepted instruction: advance the machine and queue its result
    function void note_instr(input in_item_t it);
      machine_t  n;
      out_item_t r;
      run_instr(mach, it, n, r);
      mach = n;
      result_q.push_back(r);
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // result transfer against the oldest expected result
    function void check_result(input out_item_t got);
      out_item_t want;
      if (result_q.size() == 0) begin
        $error("result transfer with nothing expected: %p", got);
        errors++;
        return;
      end
      want = result_q.pop_front();
      checked++;
      if (got.next_line !== want.next_line) begin
        $error("next_line: expected %0d, got %0d", want.next_line, got.next_line);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $error("halted: expected %0b, got %0b", want.halted, got.halted);
        errors++;
      end
      if (got.print_valid !== want.print_valid) begin
        $error("print_valid: expected %0b, got %0b", want.print_valid, got.print_valid);
        errors++;
      end
      if (got.print_value !== want.print_value) begin
        $error("print_value: expected %0d, got %0d", want.print_value, got.print_value);
        errors++;
      end
      if (got.divide_error !== want.divide_error) begin
        $error("divide_error: expected %0b, got %0b", want.divide_error, got.divide_error);
        errors++;
      end
      if (want.print_valid) prints++;
      if (want.divide_error) div_errors++;
      if (want.halted) halts++;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_we;
  logic [LEN_W-1:0]   cfg_wdata;

  exec_scoreboard sb = new();
  int             n_settings;

  four_register_instruction_execute_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // operand values leaning towards the edges of the signed range
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      5: return DATA_W'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t instr(input logic [3:0] op,
                                     input logic f_is_reg, input logic [1:0] f_reg,
                                     input logic [DATA_W-1:0] f_imm,
                                     input logic s_is_reg, input logic [1:0] s_reg,
                                     input logic [DATA_W-1:0] s_imm,
                                     input logic [LINE_W-1:0] tgt,
                                     input logic [DATA_W-1:0] rd);
    in_item_t it;
    it.operation = op;
    it.first_is_reg = f_is_reg;
    it.first_reg = f_reg;
    it.first_imm = f_imm;
    it.second_is_reg = s_is_reg;
    it.second_reg = s_reg;
    it.second_imm = s_imm;
    it.jump_target = tgt;
    it.read_value = rd;
    return it;
  endfunction

  // random instruction, jumps mostly aimed inside a program of len lines
  function automatic in_item_t rand_instr(input int len);
    in_item_t it;
    it.operation = ($urandom_range(0, 6) == 0) ? OP_READ : 4'($urandom_range(0, 15));
    it.first_is_reg = 1'($urandom_range(0, 1));
    it.first_reg = 2'($urandom_range(0, 3));
    it.first_imm = pick_value();
    it.second_is_reg = 1'($urandom_range(0, 1));
    it.second_reg = 2'($urandom_range(0, 3));
    it.second_imm = pick_value();
    it.jump_target = LINE_W'($urandom_range(0, 127));
    it.read_value = pick_value();
    if (it.operation >= OP_JMP && it.operation <= OP_JLE) begin
      if ($urandom_range(0, 9) != 0) it.jump_target = LINE_W'($urandom_range(0, len - 1));
      // equal operands so the equality forms get taken too
      if ($urandom_range(0, 9) < 3) begin
        it.second_is_reg = it.first_is_reg;
        it.second_reg = it.first_reg;
        it.second_imm = it.first_imm;
      end
    end
    return it;
  endfunction

  // one input transfer, after a random gap
  task automatic send_instr(input in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_instr(it);
  endtask

  // hold off the sender until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.set_prog_len(v);
    n_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random instructions, steered away from halting the program
  task automatic run_random(input int count);
    in_item_t it;
    int       len;
    repeat (count) begin
      len = sb.cap_len(sb.mach.prog_len);
      it = rand_instr(len);
      if (sb.would_halt(it)) begin
        it.operation = OP_JMP;
        it.jump_target = LINE_W'($urandom_range(0, len - 1));
      end
      if ($urandom_range(0, 49) == 0) drain();
      send_instr(it);
    end
  endtask

  // result side: runs of ready broken by stalls
  initial begin
    int run;
    int stall;
    out_ready = 1'b0;
    forever begin
      run = $urandom_range(1, 24);
      repeat (run) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // run limit
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("four_register_instruction_execute_unit test failed");
    $finish;
  end

  // main sequence
  initial begin
    logic [LEN_W-1:0] lens [5];
    int               counts [5];
    int               ending;
    int               len;
    lens = '{8'd128, 8'd1, 8'd2, 8'd200, 8'd37};
    counts = '{150, 15, 30, 150, 150};
    n_settings = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_length(8'd255);

    // directed: edge values, every operation, wrap and divide corners
    send_instr(instr(OP_READ, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
    send_instr(instr(OP_READ, 0, 1, 0, 0, 0, 0, 0, 32'hffff_ffff));
    send_instr(instr(OP_READ, 0, 2, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    send_instr(instr(OP_PRINT, 1, 0, 0, 0, 0, 0, 0, 0));
    send_instr(instr(OP_PRINT, 0, 0, 32'h8000_0001, 0, 0, 0, 0, 0));
    // most negative over minus one wraps
    send_instr(instr(OP_DIV, 1, 0, 0, 0, 1, 0, 0, 0));
    // zero divisor
    send_instr(instr(OP_DIV, 0, 0, 32'd7, 0, 3, 0, 0, 0));
    send_instr(instr(OP_ADD, 1, 2, 0, 0, 2, 0, 0, 0));
    send_instr(instr(OP_SUB, 0, 0, 32'd1, 0, 3, 0, 0, 0));
    send_instr(instr(OP_MUL, 0, 0, 32'h7fff_ffff, 0, 3, 0, 0, 0));
    send_instr(instr(OP_MOV, 0, 0, 32'h1234_5678, 0, 0, 0, 0, 0));
    // truncation toward zero with a negative divisor
    send_instr(instr(OP_DIV, 0, 0, 32'd7, 0, 2, 0, 0, 0));
    send_instr(instr(OP_NOOP, 1, 3, '1, 1, 3, '1, '1, '1));
    send_instr(instr(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
    send_instr(instr(OP_JMP, 0, 0, 0, 0, 0, 0, 7'd20, 0));
    send_instr(instr(OP_JE, 1, 2, 0, 0, 0, 32'hffff_fffd, 7'd30, 0));
    send_instr(instr(OP_JNE, 1, 2, 0, 0, 0, 32'hffff_fffd, 7'd5, 0));
    send_instr(instr(OP_JG, 0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 7'd40, 0));
    send_instr(instr(OP_JGE, 1, 0, 0, 1, 0, 0, 7'd50, 0));
    send_instr(instr(OP_JL, 0, 0, 32'h8000_0000, 1, 1, 0, 7'd60, 0));
    send_instr(instr(OP_JLE, 0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 7'd126, 0));
    send_instr(instr(OP_PRINT, 1, 3, 0, 0, 0, 0, 0, 0));
    send_instr(instr(OP_JMP, 0, 0, 0, 0, 0, 0, 7'd0, 0));
    // signed rather than unsigned comparison
    send_instr(instr(OP_JL, 0, 0, '1, 0, 0, 32'd1, 7'd3, 0));
    send_instr(instr(OP_JG, 0, 0, '1, 0, 0, 32'd1, 7'd9, 0));

    run_random(110);

    // further program lengths, line parked at zero before each change
    for (int k = 0; k < 5; k++) begin
      send_instr(instr(OP_JMP, 0, 0, 0, 0, 0, 0, 7'd0, 0));
      drain();
      write_length(lens[k]);
      run_random(counts[k]);
    end

    // bring the program to its end, then keep feeding a halted block
    drain();
    len = sb.cap_len(sb.mach.prog_len);
    ending = $urandom_range(END_SHRINK, END_RUN_OFF);
    case (ending)
      END_SHRINK: begin
        write_length(8'd0);
        send_instr(rand_instr(MAX_LINES));
      end
      END_JUMP_OUT: begin
        send_instr(instr(OP_JMP, 0, 0, 0, 0, 0, 0, LINE_W'($urandom_range(len, 127)), 0));
      end
      default: begin
        send_instr(instr(OP_JMP, 0, 0, 0, 0, 0, 0, LINE_W'(len - 1), 0));
        send_instr(instr(OP_NOOP, 0, 0, 0, 0, 0, 0, 0, 0));
      end
    endcase
    repeat (8) send_instr(rand_instr(MAX_LINES));
    drain();
    write_length((ending == END_SHRINK) ? 8'd128 : 8'd0);
    repeat (4) send_instr(rand_instr(MAX_LINES));
    drain();
    repeat (TAIL) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("%0d results checked over %0d program length writes, end mode %0d",
             sb.checked, n_settings, ending);
    $display("%0d prints, %0d divide errors, %0d halted answers",
             sb.prints, sb.div_errors, sb.halts);
    if (sb.errors == 0) begin
      $display("four_register_instruction_execute_unit test passed");
    end else begin
      $display("four_register_instruction_execute_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/frxu_pkg.sv
rtl/frxu_ram.sv
rtl/frxu_div.sv
rtl/frxu_dp.sv
rtl/frxu_ctrl.sv
rtl/four_register_instruction_execute_unit.sv
sim/tb_top.sv
